// ----- hdl/cle_pkg.sv -----
package cle_pkg;

	// Line buffer depth; the usable capacity never exceeds it nor 256.
	localparam int unsigned LINE_DEPTH = 256;
	localparam int unsigned CapLimitInt = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;
	localparam logic [8:0] CAP_LIMIT = 9'(CapLimitInt);
	localparam logic [8:0] CAP_RESET = 9'd256;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_STORE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// What one item turns into on the result side.
	typedef enum logic [1:0] {
		OP_NEWLINE,
		OP_ERASE,
		OP_STORE,
		OP_BELL
	} op_t;

	typedef enum logic [1:0] {
		STEP_FIRST  = 2'd0,
		STEP_SECOND = 2'd1,
		STEP_THIRD  = 2'd2
	} step_t;

	typedef struct packed {
		logic       vld;
		op_t        op;
		logic [7:0] data;
		logic [7:0] index;
	} burst_t;

endpackage

// ----- hdl/cle_if.sv -----
interface cle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] line_index;
	logic       last;

	modport source (output valid, output kind, output data_byte, output line_index,
		output last, input ready);
	modport sink   (input valid, input kind, input data_byte, input line_index,
		input last, output ready);
endinterface

// ----- hdl/cle_decode.sv -----
module cle_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [8:0]      cfg_wdata,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	output cle_pkg::burst_t burst
);
	import cle_pkg::*;

	logic [8:0] cap_q;
	logic       cr_q;
	logic [7:0] count_q;

	logic [8:0] cap_eff;
	logic       drop, is_nl, is_erase, fits;

	assign cap_eff  = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;
	assign drop     = (rx_byte == CH_LF) && cr_q;
	assign is_nl    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
	assign fits     = ({1'b0, count_q} + 9'd1) < cap_eff;

	always_comb begin
		burst.vld   = 1'b0;
		burst.op    = OP_BELL;
		burst.data  = rx_byte;
		burst.index = count_q;
		priority if (drop) begin
			burst.vld = 1'b0;
		end else if (is_nl) begin
			burst.vld = 1'b1;
			burst.op  = OP_NEWLINE;
		end else if (is_erase) begin
			burst.vld = (count_q != 8'd0);
			burst.op  = OP_ERASE;
		end else begin
			burst.vld = 1'b1;
			burst.op  = fits ? OP_STORE : OP_BELL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			cr_q    <= 1'b0;
			count_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept && !drop) begin
				cr_q <= (rx_byte == CH_CR);
				priority if (is_nl) begin
					count_q <= 8'd0;
				end else if (is_erase) begin
					if (count_q != 8'd0) begin
						count_q <= count_q - 8'd1;
					end
				end else if (fits) begin
					count_q <= count_q + 8'd1;
				end else begin
					// Bell: hold the count.
					count_q <= count_q;
				end
			end
		end
	end

endmodule

// ----- hdl/cle_emit.sv -----
module cle_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  cle_pkg::burst_t burst,
	input  logic            rx_valid,
	output logic            rx_ready,
	cle_res_if.source       res
);
	import cle_pkg::*;

	logic       busy_q;
	op_t        op_q;
	logic [7:0] data_q;
	logic [7:0] index_q;
	step_t      step_q;

	kind_t kind_c;
	logic  final_c;
	logic  take, accept;

	always_comb begin
		kind_c         = KIND_ECHO;
		res.data_byte  = CH_NUL;
		res.line_index = 8'd0;
		final_c        = 1'b0;
		unique case (op_q)
			OP_NEWLINE: begin
				unique case (step_q)
					STEP_FIRST:  res.data_byte = CH_CR;
					STEP_SECOND: res.data_byte = CH_LF;
					default: begin
						kind_c         = KIND_END;
						res.line_index = index_q;
						final_c        = 1'b1;
					end
				endcase
			end
			OP_ERASE: begin
				unique case (step_q)
					STEP_SECOND: res.data_byte = CH_SP;
					STEP_FIRST:  res.data_byte = CH_BS;
					default: begin
						res.data_byte = CH_BS;
						final_c       = 1'b1;
					end
				endcase
			end
			OP_STORE: begin
				res.data_byte = data_q;
				if (step_q != STEP_FIRST) begin
					kind_c         = KIND_STORE;
					res.line_index = index_q;
					final_c        = 1'b1;
				end
			end
			default: begin
				res.data_byte = CH_BEL;
				final_c       = 1'b1;
			end
		endcase
	end

	assign res.kind  = kind_c;
	assign res.last  = final_c;
	assign res.valid = busy_q;

	assign take     = busy_q && res.ready;
	assign rx_ready = !busy_q || (take && final_c);
	assign accept   = rx_valid && rx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_FIRST;
		end else begin
			if (accept) begin
				busy_q <= burst.vld;
				step_q <= STEP_FIRST;
			end else if (take) begin
				if (final_c) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= (step_q == STEP_FIRST) ? STEP_SECOND : STEP_THIRD;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= burst.op;
			data_q  <= burst.data;
			index_q <= burst.index;
		end
	end

endmodule

// ----- hdl/console_line_editor.sv -----
// Console line editor: received bytes in, echo and line-buffer writes out.
// The first result of an item is offered in the cycle after the item is taken.
// An item holds the result register until the last of its one to three results is taken;
// an item with no results (dropped LF, erase on an empty line) never occupies it.
// The next item is taken in the same cycle the final result of the previous one leaves.
// Reset (arst_n low, asynchronous): line count and CR flag clear, capacity goes to 256.
module console_line_editor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	cle_rx_if.sink     rx,
	cle_res_if.source  res
);
	import cle_pkg::*;

	// Decoded item: what to emit, the stored byte, and the line position.
	burst_t burst;
	logic   accept;

	assign accept = rx.valid && rx.ready;

	// Decode the received byte against the line state and advance that state
	// at the moment the item is taken, so the next item sees it right away.
	cle_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.rx_byte   (rx.rx_byte),
		.burst     (burst)
	);

	// Hold the decoded item and step through its results, one per cycle while res is ready;
	// drop items that produce nothing without occupying the output.
	cle_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (burst),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.res      (res)
	);

endmodule

// ----- hdl/cle_checker.sv -----
module cle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_data_byte,
	input logic [7:0] res_line_index,
	input logic       res_last
);
	import cle_pkg::*;

	// A line end carries a zero byte.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_END) |-> res_data_byte == CH_NUL)
		else $error("line end with nonzero data");

	// Line end and store are always the final result of their item.
	a_write_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_END || res_kind == KIND_STORE) |-> res_last)
		else $error("buffer write not marked last");

	// Echo results carry position zero.
	a_echo_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_ECHO) |-> res_line_index == 8'd0)
		else $error("echo with nonzero line index");

	// The rest of an item follows directly after a non-final result is taken.
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid)
		else $error("item results broken off");

endmodule

bind console_line_editor cle_checker u_cle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_kind       (res.kind),
	.res_data_byte  (res.data_byte),
	.res_line_index (res.line_index),
	.res_last       (res.last)
);

// ----- verif/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cle_pkg::*;

	// Give up long after the slowest legal run would have ended.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles to let pass once the last expected result is in; covers an item
	// that makes no result and is still being retired.
	localparam int SETTLE_CYCLES = 4;

	// One terminal echo or line-buffer write as it leaves the block.
	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] index;
		logic       last;
	} line_write_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	cle_rx_if  rx_ch ();
	cle_res_if res_ch ();

	console_line_editor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	// Editor state as the testbench sees it: CR flag, line length, capacity.
	logic       cr_seen;
	logic [7:0] line_len;
	logic [8:0] cap_reg;

	// Echoes and writes still owed by the block, oldest first.
	line_write_t due_writes[$];

	int n_items   = 0;
	int n_results = 0;
	int n_errors  = 0;
	int cycles    = 0;
	int hold_left = 0;   // cycles the receiver still has to hold off
	bit calm      = 1'b0; // no random idling on either side while set

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends up here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				due_writes.size());
			$display("testbench failed");
			$finish;
		end
	end

	// Count down a receiver hold-off started by a test.
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	task automatic report_mismatch(input string what);
		n_errors++;
		if (n_errors <= 25)
			$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic void push_write(kind_t k, logic [7:0] d, logic [7:0] i, logic l);
		line_write_t w;
		w.kind  = k;
		w.data  = d;
		w.index = i;
		w.last  = l;
		due_writes.push_back(w);
	endfunction

	// Work out what one received byte must turn into, and advance the state.
	function automatic void apply_rx_byte(logic [7:0] b);
		logic [7:0] c;
		int         room;
		c = b;
		// Drop LF right after a kept CR; the flag stays so a run is dropped.
		if (c == CH_LF && cr_seen)
			return;
		cr_seen = (c == CH_CR);
		if (c == CH_CR)
			c = CH_LF;
		// Capacity above what the buffer holds is clamped.
		room = (cap_reg > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(cap_reg);
		if (c == CH_LF) begin
			push_write(KIND_ECHO, CH_CR, 8'd0, 1'b0);
			push_write(KIND_ECHO, CH_LF, 8'd0, 1'b0);
			push_write(KIND_END, CH_NUL, line_len, 1'b1);
			line_len = 8'd0;
		end else if (c == CH_BS || c == CH_DEL) begin
			// Erase on an empty line does nothing visible.
			if (line_len != 8'd0) begin
				push_write(KIND_ECHO, CH_BS, 8'd0, 1'b0);
				push_write(KIND_ECHO, CH_SP, 8'd0, 1'b0);
				push_write(KIND_ECHO, CH_BS, 8'd0, 1'b1);
				line_len = line_len - 8'd1;
			end
		end else if (int'(line_len) + 1 < room) begin
			push_write(KIND_ECHO, c, 8'd0, 1'b0);
			push_write(KIND_STORE, c, line_len, 1'b1);
			line_len = line_len + 8'd1;
		end else begin
			push_write(KIND_ECHO, CH_BEL, 8'd0, 1'b1);
		end
	endfunction

	// Result side: check each accepted result, then pick ready for the next cycle.
	always @(posedge clk) begin : result_check
		line_write_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			n_results++;
			if (due_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d data %02h index %0d",
					res_ch.kind, res_ch.data_byte, res_ch.line_index));
			end else begin
				w = due_writes.pop_front();
				if (res_ch.kind !== w.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", res_ch.kind, w.kind));
				if (res_ch.data_byte !== w.data)
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						res_ch.data_byte, w.data));
				if (res_ch.line_index !== w.index)
					report_mismatch($sformatf("line_index %0d, expected %0d",
						res_ch.line_index, w.index));
				if (res_ch.last !== w.last)
					report_mismatch($sformatf("last %0b, expected %0b", res_ch.last, w.last));
			end
		end
		// Hold-off wins; otherwise stall about a third of the time unless calm.
		if (hold_left != 0)
			res_ch.ready <= 1'b0;
		else if (calm)
			res_ch.ready <= 1'b1;
		else
			res_ch.ready <= ($urandom_range(99) >= 33);
	end

	// Offer one byte, maybe after a random gap, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 33)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		apply_rx_byte(b);
		n_items++;
	endtask

	// Stop offering, wait for every owed result, then let the block settle.
	task automatic drain;
		rx_ch.valid <= 1'b0;
		while (due_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_capacity(input logic [8:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cap_reg  = v;
	endtask

	// Printable text with some erasing and some arbitrary bytes, then a line
	// ending picked among CR, LF, CR LF and CR LF LF.
	task automatic send_random_line(input int max_len);
		int len;
		int r;
		len = $urandom_range(max_len, 0);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 6)
				send_byte(CH_BS);
			else if (r < 10)
				send_byte(CH_DEL);
			else if (r < 16)
				send_byte(8'($urandom_range(255)));
			else
				send_byte(8'($urandom_range(8'h7E, 8'h20)));
		end
		case ($urandom_range(3))
			0: send_byte(CH_CR);
			1: send_byte(CH_LF);
			2: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
			default: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
				send_byte(CH_LF);
			end
		endcase
	endtask

	// Line endings at reset capacity: bare LF, CR LF, a dropped LF run, CR CR.
	task automatic test_line_endings;
		send_byte(CH_LF);
		send_byte("a");
		send_byte("b");
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(CH_CR);
		send_byte(CH_CR);
		send_byte("c");
		send_byte(CH_LF);
		drain();
	endtask

	// Erase on empty and non-empty lines, both erase codes, and a byte after CR that
	// clears the CR flag; also the all-zero and all-one data bytes.
	task automatic test_erase;
		send_byte(CH_BS);
		send_byte(CH_DEL);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_DEL);
		send_byte(CH_BS);
		send_byte(CH_BS);
		send_byte(CH_CR);
		send_byte(CH_BS);
		send_byte(CH_LF);
		drain();
	endtask

	// Capacities of zero and one leave no room; two leaves room for one byte.
	task automatic test_tiny_capacity;
		write_capacity(9'd0);
		send_byte("q");
		drain();
		write_capacity(9'd1);
		send_byte("q");
		send_byte(CH_BS);
		drain();
		write_capacity(9'd2);
		send_byte("a");
		send_byte("b");
		send_byte(CH_LF);
		drain();
	endtask

	// Shrink capacity below the current count: bytes stay, new ones ring the bell.
	task automatic test_shrink_mid_line;
		write_capacity(CAP_RESET);
		for (int i = 0; i < 5; i++)
			send_byte(8'("a" + i));
		drain();
		write_capacity(9'd3);
		send_byte("z");
		send_byte(CH_DEL);
		send_byte(CH_LF);
		drain();
	endtask

	// Fill a whole line with no idling: at capacity 24 the last stored index
	// is 22, then the bell, then a line end of length 23.
	task automatic test_full_line;
		logic [7:0] b;
		write_capacity(9'd24);
		calm = 1'b1;
		for (int i = 0; i < 24; i++) begin
			do b = 8'($urandom_range(255));
			while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
			send_byte(b);
		end
		send_byte(CH_LF);
		drain();
		calm = 1'b0;
	endtask

	// Hold the result side off for a long stretch while bytes keep coming, so
	// the block fills up and stops taking input.
	task automatic test_backpressure;
		write_capacity(9'd12);
		calm = 1'b1;
		hold_left <= 120;
		for (int i = 0; i < 4; i++)
			send_random_line(6);
		drain();
		calm = 1'b0;
	endtask

	// Random lines under several capacities, small ones to reach the bell often.
	task automatic test_random_lines;
		int start;
		logic [8:0] caps[4];
		caps[0] = 9'($urandom_range(12, 1));
		caps[1] = CAP_RESET;
		caps[2] = 9'($urandom_range(511, 257));
		caps[3] = 9'd16;
		start = n_items;
		for (int p = 0; p < 4; p++) begin
			write_capacity(caps[p]);
			while (n_items - start < (p + 1) * 12)
				send_random_line(int'(caps[p] > 20 ? 20 : caps[p] + 2));
			drain();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = 9'd0;
		rx_ch.valid     = 1'b0;
		rx_ch.rx_byte   = 8'd0;
		res_ch.ready    = 1'b0;
		cr_seen         = 1'b0;
		line_len        = 8'd0;
		cap_reg         = CAP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_line_endings();
		test_erase();
		test_tiny_capacity();
		test_shrink_mid_line();
		test_full_line();
		test_backpressure();
		test_random_lines();

		$display("sent %0d bytes and checked %0d results", n_items, n_results);
		$display("capacities 0 to 511, erase, line endings, full line, long receiver stall");
		if (n_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/cle_pkg.sv
hdl/cle_if.sv
hdl/cle_decode.sv
hdl/cle_emit.sv
hdl/console_line_editor.sv
hdl/cle_checker.sv
verif/testbench.sv
